// ===== hw/rtl/cht_pkg.sv =====
`timescale 1ns / 1ps

package cht_pkg;

  // built geometry
  localparam int DEPTH    = 16;
  localparam int KEY_BITS = 31;

  // derived widths
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int SIZE_W = $clog2(DEPTH + 1);
  localparam int REM_W  = IDX_W + 1;

  // fixed field widths
  localparam int ACT_W  = 2;
  localparam int CFG_W  = 5;
  localparam int SLOT_W = 4;
  localparam int EVC_W  = 5;

  localparam logic [CFG_W-1:0] SIZE_RESET = 5'd16;

  // action codes
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ERASE  = 2'd2;

  // table select
  localparam logic TBL_FIRST  = 1'b0;
  localparam logic TBL_SECOND = 1'b1;

  // write request into the table storage
  typedef struct packed {
    logic                en;
    logic                tbl;
    logic [IDX_W-1:0]    idx;
    logic [KEY_BITS-1:0] key;
    logic                valid;
  } cht_wr_t;

  // read data of one table
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic                valid;
  } cht_rd_t;

endpackage

// ===== hw/rtl/cht_div.sv =====
`timescale 1ns / 1ps

module cht_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [cht_pkg::KEY_BITS-1:0] dividend,
  input  logic [cht_pkg::SIZE_W-1:0]   divisor,
  output logic                         done,
  output logic [cht_pkg::KEY_BITS-1:0] quo,
  output logic [cht_pkg::IDX_W-1:0]    rem
);
  import cht_pkg::*;

  localparam int CNT_W = $clog2(KEY_BITS);

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [KEY_BITS-1:0] q_r;
  logic [IDX_W-1:0]    rem_r;
  logic [SIZE_W-1:0]   d_r;

  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    d_ext;
  logic                ge;
  logic [IDX_W-1:0]    rem_nxt;
  logic [KEY_BITS-1:0] q_nxt;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem_r, q_r[KEY_BITS-1]};
    d_ext   = REM_W'(d_r);
    ge      = (rem_sh >= d_ext);
    rem_nxt = ge ? IDX_W'(rem_sh - d_ext) : IDX_W'(rem_sh);
    q_nxt   = {q_r[KEY_BITS-2:0], ge};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(KEY_BITS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = rem_r;

endmodule

// ===== hw/rtl/cht_store.sv =====
`timescale 1ns / 1ps

module cht_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cht_pkg::cht_wr_t          wr,
  input  logic [cht_pkg::IDX_W-1:0] rd1_idx,
  input  logic [cht_pkg::IDX_W-1:0] rd2_idx,
  output cht_pkg::cht_rd_t          rd1,
  output cht_pkg::cht_rd_t          rd2
);
  import cht_pkg::*;

  logic [KEY_BITS-1:0] t1_key_r [DEPTH];
  logic [KEY_BITS-1:0] t2_key_r [DEPTH];
  logic [DEPTH-1:0]    t1_vld_r;
  logic [DEPTH-1:0]    t2_vld_r;
  cht_rd_t             rd1_r;
  cht_rd_t             rd2_r;

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_vld_r <= '0;
      t2_vld_r <= '0;
    end else if (wr.en) begin
      if (wr.tbl == TBL_FIRST) begin
        t1_vld_r[wr.idx] <= wr.valid;
      end else begin
        t2_vld_r[wr.idx] <= wr.valid;
      end
    end
  end

  // stored keys
  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (wr.tbl == TBL_FIRST) begin
        t1_key_r[wr.idx] <= wr.key;
      end else begin
        t2_key_r[wr.idx] <= wr.key;
      end
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    rd1_r.key   <= t1_key_r[rd1_idx];
    rd1_r.valid <= t1_vld_r[rd1_idx];
    rd2_r.key   <= t2_key_r[rd2_idx];
    rd2_r.valid <= t2_vld_r[rd2_idx];
  end

  assign rd1 = rd1_r;
  assign rd2 = rd2_r;

endmodule

// ===== hw/rtl/cht_seq.sv =====
`timescale 1ns / 1ps

module cht_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [cht_pkg::ACT_W-1:0]    in_action,
  input  logic [cht_pkg::KEY_BITS-1:0] in_key,
  input  logic [cht_pkg::SIZE_W-1:0]   size,
  output logic                         busy,
  // divider
  output logic                         div_start,
  output logic [cht_pkg::KEY_BITS-1:0] div_dividend,
  output logic [cht_pkg::SIZE_W-1:0]   div_divisor,
  input  logic                         div_done,
  input  logic [cht_pkg::KEY_BITS-1:0] div_quo,
  input  logic [cht_pkg::IDX_W-1:0]    div_rem,
  // table storage
  output cht_pkg::cht_wr_t             wr,
  output logic [cht_pkg::IDX_W-1:0]    rd1_idx,
  output logic [cht_pkg::IDX_W-1:0]    rd2_idx,
  input  cht_pkg::cht_rd_t             rd1,
  input  cht_pkg::cht_rd_t             rd2,
  // result
  output logic                         out_valid,
  output logic                         out_found,
  output logic                         out_which_table,
  output logic [cht_pkg::SLOT_W-1:0]   out_slot,
  output logic                         out_status,
  output logic [cht_pkg::KEY_BITS-1:0] out_dropped_key,
  output logic [cht_pkg::EVC_W-1:0]    out_evictions
);
  import cht_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV1  = 3'd1;
  localparam logic [2:0] S_DIV2  = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_PLACE = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [ACT_W-1:0]    act_r;
  logic [KEY_BITS-1:0] carry_r;
  logic [SIZE_W-1:0]   s_r;
  logic [SIZE_W-1:0]   ev_r;
  logic                in_first_r;
  logic [IDX_W-1:0]    idx1_r;
  logic [IDX_W-1:0]    idx2_r;

  logic                ov_r;
  logic                found_r;
  logic                tbl_r;
  logic [SLOT_W-1:0]   slot_r;
  logic                status_r;
  logic [KEY_BITS-1:0] drop_r;
  logic [EVC_W-1:0]    evc_r;

  logic                hit1, hit2;
  logic                pl_valid;
  logic [KEY_BITS-1:0] pl_old;
  logic [IDX_W-1:0]    pl_idx;
  logic [SIZE_W-1:0]   ev_nxt;
  logic                is_insert;

  assign is_insert = (act_r == ACT_INSERT);

  // probe and placement decode
  always_comb begin
    hit1     = rd1.valid && (rd1.key == carry_r);
    hit2     = rd2.valid && (rd2.key == carry_r);
    pl_valid = in_first_r ? rd1.valid : rd2.valid;
    pl_old   = in_first_r ? rd1.key : rd2.key;
    pl_idx   = in_first_r ? idx1_r : idx2_r;
    ev_nxt   = ev_r + 1'b1;
  end

  // the registered table data for a read address arrives in the next cycle
  assign rd1_idx     = ((state_r == S_DIV1) && div_done) ? div_rem : idx1_r;
  assign rd2_idx     = ((state_r == S_DIV2) && div_done) ? div_rem : idx2_r;
  assign div_divisor = (state_r == S_IDLE) ? size : s_r;

  // next state, divider launch and table writes
  always_comb begin
    state_nxt    = state_r;
    div_start    = 1'b0;
    div_dividend = div_quo;
    wr           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_action == ACT_LOOKUP || in_action == ACT_INSERT ||
              in_action == ACT_ERASE) begin
            div_start    = 1'b1;
            div_dividend = in_key;
            state_nxt    = S_DIV1;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_DIV1: begin
        if (div_done) begin
          if (is_insert && in_first_r) begin
            state_nxt = S_PLACE;
          end else begin
            div_start    = 1'b1;
            div_dividend = div_quo;
            state_nxt    = S_DIV2;
          end
        end
      end
      S_DIV2: begin
        if (div_done) begin
          state_nxt = is_insert ? S_PLACE : S_PROBE;
        end
      end
      S_PROBE: begin
        if (act_r == ACT_ERASE && (hit1 || hit2)) begin
          wr.en    = 1'b1;
          wr.tbl   = hit1 ? TBL_FIRST : TBL_SECOND;
          wr.idx   = hit1 ? idx1_r : idx2_r;
          wr.key   = '0;
          wr.valid = 1'b0;
        end
        state_nxt = S_IDLE;
      end
      S_PLACE: begin
        wr.en    = 1'b1;
        wr.tbl   = in_first_r ? TBL_FIRST : TBL_SECOND;
        wr.idx   = pl_idx;
        wr.key   = carry_r;
        wr.valid = 1'b1;
        if (!pl_valid || ev_nxt >= s_r) begin
          state_nxt = S_IDLE;
        end else begin
          // displaced key goes on to the other table
          div_start    = 1'b1;
          div_dividend = pl_old;
          state_nxt    = S_DIV1;
        end
      end
      S_RESP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= (state_r == S_PROBE) || (state_r == S_RESP) ||
                 ((state_r == S_PLACE) && (!pl_valid || ev_nxt >= s_r));
    end
  end

  // item context
  always_ff @(posedge clk) begin
    priority case (1'b1)
      (state_r == S_IDLE) && start: begin
        act_r      <= in_action;
        carry_r    <= in_key;
        s_r        <= size;
        ev_r       <= '0;
        in_first_r <= 1'b1;
      end
      (state_r == S_DIV1) && div_done: begin
        idx1_r <= div_rem;
      end
      (state_r == S_DIV2) && div_done: begin
        idx2_r <= div_rem;
      end
      (state_r == S_PLACE) && pl_valid: begin
        carry_r    <= pl_old;
        in_first_r <= !in_first_r;
        ev_r       <= ev_nxt;
      end
      default: begin
      end
    endcase
  end

  // result registers
  always_ff @(posedge clk) begin
    if (state_r == S_PROBE) begin
      found_r  <= hit1 || hit2;
      tbl_r    <= !hit1 && hit2;
      slot_r   <= hit1 ? SLOT_W'(idx1_r) : (hit2 ? SLOT_W'(idx2_r) : '0);
      status_r <= 1'b0;
      drop_r   <= '0;
      evc_r    <= '0;
    end else if (state_r == S_PLACE) begin
      found_r  <= 1'b0;
      tbl_r    <= 1'b0;
      slot_r   <= '0;
      status_r <= pl_valid;
      drop_r   <= pl_valid ? pl_old : '0;
      evc_r    <= pl_valid ? EVC_W'(ev_nxt) : EVC_W'(ev_r);
    end else if (state_r == S_RESP) begin
      found_r  <= 1'b0;
      tbl_r    <= 1'b0;
      slot_r   <= '0;
      status_r <= 1'b0;
      drop_r   <= '0;
      evc_r    <= '0;
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = ov_r;
  assign out_found       = found_r;
  assign out_which_table = tbl_r;
  assign out_slot        = slot_r;
  assign out_status      = status_r;
  assign out_dropped_key = drop_r;
  assign out_evictions   = evc_r;

endmodule

// ===== hw/rtl/cuckoo_hash_table_top.sv =====
`timescale 1ns / 1ps
// channel   | ports                                   | handshake
// ----------+-----------------------------------------+---------------------------
// input     | in_action, in_key                       | start high, busy low
// result    | out_found .. out_evictions              | out_valid, one cycle
// config    | psel penable pwrite paddr pwdata prdata | apb, pready tied high
//
// a lookup or erase makes two passes of the shared one-bit-per-cycle divider
// for the two hashes, then a probe state.
// an insert makes one divider pass per table-one placement and two per
// table-two placement, up to size_in_use placements.
// the unused action code skips the divider and answers from the response state.
// busy stays high until the result strobe; the result cannot be stalled.
// synchronous reset empties both tables at once through their valid bits.

module cuckoo_hash_table_top (
  input  logic                         clk,
  input  logic                         rst_n,
  // input item
  input  logic                         start,
  output logic                         busy,
  input  logic [cht_pkg::ACT_W-1:0]    in_action,
  input  logic [cht_pkg::KEY_BITS-1:0] in_key,
  // result item
  output logic                         out_valid,
  output logic                         out_found,
  output logic                         out_which_table,
  output logic [cht_pkg::SLOT_W-1:0]   out_slot,
  output logic                         out_status,
  output logic [cht_pkg::KEY_BITS-1:0] out_dropped_key,
  output logic [cht_pkg::EVC_W-1:0]    out_evictions,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import cht_pkg::*;

  logic [CFG_W-1:0]    cfg_size_r;
  logic [SIZE_W-1:0]   eff_size;
  logic                cfg_wr;

  logic                div_start;
  logic [KEY_BITS-1:0] div_dividend;
  logic [SIZE_W-1:0]   div_divisor;
  logic                div_done;
  logic [KEY_BITS-1:0] div_quo;
  logic [IDX_W-1:0]    div_rem;

  cht_wr_t             wr;
  logic [IDX_W-1:0]    rd1_idx;
  logic [IDX_W-1:0]    rd2_idx;
  cht_rd_t             rd1;
  cht_rd_t             rd2;

  // size register
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_size_r <= SIZE_RESET;
    end else if (cfg_wr) begin
      cfg_size_r <= pwdata[CFG_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(cfg_size_r) : 32'd0;

  // clamp the size to 1..DEPTH
  always_comb begin
    if (cfg_size_r == '0) begin
      eff_size = SIZE_W'(1);
    end else if (32'(cfg_size_r) > DEPTH) begin
      eff_size = SIZE_W'(DEPTH);
    end else begin
      eff_size = SIZE_W'(cfg_size_r);
    end
  end

  cht_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_action       (in_action),
    .in_key          (in_key),
    .size            (eff_size),
    .busy            (busy),
    .div_start       (div_start),
    .div_dividend    (div_dividend),
    .div_divisor     (div_divisor),
    .div_done        (div_done),
    .div_quo         (div_quo),
    .div_rem         (div_rem),
    .wr              (wr),
    .rd1_idx         (rd1_idx),
    .rd2_idx         (rd2_idx),
    .rd1             (rd1),
    .rd2             (rd2),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_which_table (out_which_table),
    .out_slot        (out_slot),
    .out_status      (out_status),
    .out_dropped_key (out_dropped_key),
    .out_evictions   (out_evictions)
  );

  cht_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  cht_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd1_idx (rd1_idx),
    .rd2_idx (rd2_idx),
    .rd1     (rd1),
    .rd2     (rd2)
  );

endmodule

// ===== hw/rtl/cht_check.sv =====
`timescale 1ns / 1ps

module cht_check (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic                         out_found,
  input logic                         out_which_table,
  input logic [cht_pkg::SLOT_W-1:0]   out_slot,
  input logic                         out_status,
  input logic [cht_pkg::EVC_W-1:0]    out_evictions
);
  import cht_pkg::*;

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

  // an accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("item accepted but block not busy");

  // results never come back to back, and only once the work is done
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy ##1 !out_valid)
    else $error("result strobe longer than one cycle or while busy");

  // a miss reports table and slot as zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> !out_which_table && (out_slot == '0))
    else $error("miss with nonzero table or slot");

  // a dropped key comes only from an insert that made evictions
  a_drop_insert: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_found && (out_evictions != '0))
    else $error("drop flag on a non-insert result");

endmodule

bind cuckoo_hash_table_top cht_check u_cht_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_found       (out_found),
  .out_which_table (out_which_table),
  .out_slot        (out_slot),
  .out_status      (out_status),
  .out_evictions   (out_evictions)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// one result item as seen on the result ports
typedef struct {
  logic                                found;
  logic                                which_table;
  logic [cht_pkg::SLOT_W-1:0]          slot;
  logic                                status;
  logic [cht_pkg::KEY_BITS-1:0]        dropped_key;
  logic [cht_pkg::EVC_W-1:0]           evictions;
} result_t;

// predicts the two-table cuckoo hash and checks every result item in order
class hash_table_scoreboard;

  logic [cht_pkg::KEY_BITS-1:0] first_keys  [cht_pkg::DEPTH];
  bit                           first_used  [cht_pkg::DEPTH];
  logic [cht_pkg::KEY_BITS-1:0] second_keys [cht_pkg::DEPTH];
  bit                           second_used [cht_pkg::DEPTH];
  logic [cht_pkg::CFG_W-1:0]    size_reg;
  result_t                      pending_results[$];

  int errors;
  int n_lookup, n_insert, n_erase, n_unused, n_hits, n_drops, max_evictions;

  function new();
    foreach (first_keys[i]) begin
      first_keys[i]  = '0;
      first_used[i]  = 1'b0;
      second_keys[i] = '0;
      second_used[i] = 1'b0;
    end
    size_reg = cht_pkg::SIZE_RESET;
  endfunction

  function void write_size(logic [cht_pkg::CFG_W-1:0] value);
    size_reg = value;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  // table length actually used: zero acts as one, above depth clamps
  function int unsigned table_len();
    int unsigned s;
    s = size_reg;
    if (s == 0) s = 1;
    if (s > cht_pkg::DEPTH) s = cht_pkg::DEPTH;
    return s;
  endfunction

  // work out the result of an accepted item and update the tables
  function void note_request(logic [cht_pkg::ACT_W-1:0] action,
                             logic [cht_pkg::KEY_BITS-1:0] key);
    result_t                      r;
    int unsigned                  s, h1, h2, h, ev;
    logic [cht_pkg::KEY_BITS-1:0] carry, old;
    bit                           in_first, placed;
    r.found       = 1'b0;
    r.which_table = cht_pkg::TBL_FIRST;
    r.slot        = '0;
    r.status      = 1'b0;
    r.dropped_key = '0;
    r.evictions   = '0;
    s  = table_len();
    h1 = key % s;
    h2 = (key / s) % s;
    case (action)
      cht_pkg::ACT_LOOKUP, cht_pkg::ACT_ERASE: begin
        if (action == cht_pkg::ACT_LOOKUP) n_lookup++;
        else n_erase++;
        // first match wins, table one before table two
        if (first_used[h1] && first_keys[h1] == key) begin
          r.found = 1'b1;
          r.slot  = h1[cht_pkg::SLOT_W-1:0];
          if (action == cht_pkg::ACT_ERASE) begin
            first_used[h1] = 1'b0;
            first_keys[h1] = '0;
          end
        end else if (second_used[h2] && second_keys[h2] == key) begin
          r.found       = 1'b1;
          r.which_table = cht_pkg::TBL_SECOND;
          r.slot        = h2[cht_pkg::SLOT_W-1:0];
          if (action == cht_pkg::ACT_ERASE) begin
            second_used[h2] = 1'b0;
            second_keys[h2] = '0;
          end
        end
        if (r.found) n_hits++;
      end
      cht_pkg::ACT_INSERT: begin
        n_insert++;
        carry    = key;
        in_first = 1'b1;
        placed   = 1'b0;
        ev       = 0;
        // displaced keys alternate tables until a free slot or the limit
        while (ev < s && !placed) begin
          if (in_first) begin
            h = carry % s;
            if (!first_used[h]) begin
              first_keys[h] = carry;
              first_used[h] = 1'b1;
              placed        = 1'b1;
            end else begin
              old           = first_keys[h];
              first_keys[h] = carry;
            end
          end else begin
            h = (carry / s) % s;
            if (!second_used[h]) begin
              second_keys[h] = carry;
              second_used[h] = 1'b1;
              placed         = 1'b1;
            end else begin
              old            = second_keys[h];
              second_keys[h] = carry;
            end
          end
          if (!placed) begin
            carry    = old;
            in_first = !in_first;
            ev++;
          end
        end
        r.evictions = ev[cht_pkg::EVC_W-1:0];
        if (ev > max_evictions) max_evictions = ev;
        if (!placed) begin
          r.status      = 1'b1;
          r.dropped_key = carry;
          n_drops++;
        end
      end
      default: n_unused++;
    endcase
    pending_results.push_back(r);
  endfunction

  function void field_check(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  // compare an accepted result item with the oldest prediction
  function void check_response(result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: result item with none expected, expected none actual found=%0h slot=%0h",
               $time, got.found, got.slot);
      return;
    end
    want = pending_results.pop_front();
    field_check("found", want.found, got.found);
    field_check("which_table", want.which_table, got.which_table);
    field_check("slot", want.slot, got.slot);
    field_check("status", want.status, got.status);
    field_check("dropped_key", want.dropped_key, got.dropped_key);
    field_check("evictions", want.evictions, got.evictions);
  endfunction

endclass

module tb;

  localparam logic [cht_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [2:0]                SIZE_ADDR  = 3'd0;
  localparam int                        IDLE_LIMIT = 20000;
  localparam int                        PHASES     = 10;
  localparam int                        PHASE_ITEMS = 65;
  localparam int                        POOL_N     = 24;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic [cht_pkg::ACT_W-1:0]      in_action;
  logic [cht_pkg::KEY_BITS-1:0]   in_key;
  logic                           out_valid;
  logic                           out_found;
  logic                           out_which_table;
  logic [cht_pkg::SLOT_W-1:0]     out_slot;
  logic                           out_status;
  logic [cht_pkg::KEY_BITS-1:0]   out_dropped_key;
  logic [cht_pkg::EVC_W-1:0]      out_evictions;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [2:0]                     paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;

  hash_table_scoreboard           sb;
  int                             idle_cycles;
  int                             n_cfg_writes;
  logic [cht_pkg::KEY_BITS-1:0]   key_pool [POOL_N];

  cuckoo_hash_table_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_which_table (out_which_table),
    .out_slot        (out_slot),
    .out_status      (out_status),
    .out_dropped_key (out_dropped_key),
    .out_evictions   (out_evictions),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // sample both channels at the rising edge; results first, then new items
  always @(posedge clk) begin : monitor
    result_t got;
    if (rst_n) begin
      if (out_valid) begin
        got.found       = out_found;
        got.which_table = out_which_table;
        got.slot        = out_slot;
        got.status      = out_status;
        got.dropped_key = out_dropped_key;
        got.evictions   = out_evictions;
        sb.check_response(got);
      end
      if (start && !busy) sb.note_request(in_action, in_key);
    end
  end

  // watchdog on cycles where neither channel moves an item
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, nothing accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // present one item and hold it until accepted
  task automatic send_item(logic [cht_pkg::ACT_W-1:0] action,
                           logic [cht_pkg::KEY_BITS-1:0] key);
    @(negedge clk);
    start     = 1'b1;
    in_action = action;
    in_key    = key;
    do @(posedge clk); while (busy);
  endtask

  // sender gap with junk on the idle input fields
  task automatic pause_sender(int n);
    if (n > 0) begin
      @(negedge clk);
      start     = 1'b0;
      in_action = cht_pkg::ACT_W'($urandom);
      in_key    = cht_pkg::KEY_BITS'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  // let every outstanding item finish before touching the register
  task automatic drain();
    pause_sender(1);
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write then read back
  task automatic write_size(logic [cht_pkg::CFG_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = SIZE_ADDR;
    pwdata  = {$urandom_range(0, 1) ? 27'($urandom) : 27'd0, value};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    sb.write_size(value);
    n_cfg_writes++;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    psel    = 1'b1;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata[cht_pkg::CFG_W-1:0] !== value) begin
      sb.errors++;
      $display("%0t: size_in_use readback mismatch, expected %0h actual %0h",
               $time, value, prdata[cht_pkg::CFG_W-1:0]);
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // mostly colliding keys from a pool, sometimes any 31-bit key
  function automatic logic [cht_pkg::KEY_BITS-1:0] pick_key();
    if ($urandom_range(0, 99) < 80) return key_pool[$urandom_range(0, POOL_N - 1)];
    return cht_pkg::KEY_BITS'($urandom);
  endfunction

  function automatic logic [cht_pkg::ACT_W-1:0] pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return cht_pkg::ACT_INSERT;
    if (r < 70) return cht_pkg::ACT_LOOKUP;
    if (r < 95) return cht_pkg::ACT_ERASE;
    return ACT_UNUSED;
  endfunction

  initial begin : stimulus
    int phase_sizes [PHASES];
    int burst_left;
    bit no_gaps;
    sb           = new();
    n_cfg_writes = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_action    = cht_pkg::ACT_LOOKUP;
    in_key       = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = SIZE_ADDR;
    pwdata       = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty table, extremes, displacement, duplicates, unused code
    send_item(cht_pkg::ACT_LOOKUP, 31'd0);
    send_item(cht_pkg::ACT_INSERT, 31'd0);
    send_item(cht_pkg::ACT_INSERT, 31'h7FFF_FFFF);
    send_item(cht_pkg::ACT_LOOKUP, 31'h7FFF_FFFF);
    send_item(cht_pkg::ACT_INSERT, 31'd16);
    send_item(cht_pkg::ACT_LOOKUP, 31'd0);
    send_item(cht_pkg::ACT_INSERT, 31'd16);
    send_item(cht_pkg::ACT_LOOKUP, 31'd16);
    send_item(cht_pkg::ACT_ERASE, 31'd16);
    send_item(cht_pkg::ACT_LOOKUP, 31'd16);
    send_item(cht_pkg::ACT_ERASE, 31'd16);
    send_item(cht_pkg::ACT_ERASE, 31'd16);
    send_item(ACT_UNUSED, 31'h7FFF_FFFF);
    send_item(ACT_UNUSED, 31'd0);
    // 256 and 0 chase each other until the displacement limit drops one
    send_item(cht_pkg::ACT_INSERT, 31'd256);
    send_item(cht_pkg::ACT_INSERT, 31'd0);
    send_item(cht_pkg::ACT_LOOKUP, 31'd256);
    send_item(cht_pkg::ACT_LOOKUP, 31'd0);
    send_item(cht_pkg::ACT_ERASE, 31'h7FFF_FFFF);
    send_item(cht_pkg::ACT_LOOKUP, 31'h5555_5555);
    send_item(cht_pkg::ACT_INSERT, 31'h2AAA_AAAA);
    send_item(cht_pkg::ACT_LOOKUP, 31'h2AAA_AAAA);
    drain();

    // random phases over several table sizes, out-of-range ones included
    phase_sizes = '{2, 16, 5, 0, 1, 31, 17, 3, 9, 16};
    phase_sizes[8] = $urandom_range(2, 16);
    for (int p = 0; p < PHASES; p++) begin
      write_size(cht_pkg::CFG_W'(phase_sizes[p]));
      foreach (key_pool[i]) begin
        if (i % 2 == 0) key_pool[i] = cht_pkg::KEY_BITS'($urandom_range(0, 1100));
        else key_pool[i] = cht_pkg::KEY_BITS'($urandom);
      end
      no_gaps    = (p % 3 == 0);
      burst_left = $urandom_range(1, 12);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(pick_action(), pick_key());
        burst_left--;
        if (burst_left == 0) begin
          if (!no_gaps) pause_sender($urandom_range(0, 15));
          burst_left = $urandom_range(1, 12);
        end
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d lookups (%0d hits incl. erases), %0d inserts, %0d erases, %0d unused",
             sb.n_lookup, sb.n_hits, sb.n_insert, sb.n_erase, sb.n_unused);
    $display("%0d size writes, %0d dropped keys, up to %0d displacements in one insert",
             n_cfg_writes, sb.n_drops, sb.max_evictions);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== cuckoo_hash_table_top.f =====
hw/rtl/cht_pkg.sv
hw/rtl/cht_div.sv
hw/rtl/cht_store.sv
hw/rtl/cht_seq.sv
hw/rtl/cuckoo_hash_table_top.sv
hw/rtl/cht_check.sv
tb/tb.sv
